@@ rtl/wpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpt_pkg: shared types and constants of the pixel transmitter
// Frame store geometry, request and register codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wpt_pkg;

  localparam int MAX_LEDS      = 256;
  localparam int BYTES_PER_LED = 3;
  localparam int BITS_PER_LED  = 8 * BYTES_PER_LED;
  localparam int LED_IDX_W     = $clog2(MAX_LEDS);
  localparam int COUNT_W       = 9;
  localparam int BITPOS_W      = $clog2(BITS_PER_LED);
  localparam int TICK_W        = 16;
  localparam int TIME_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef logic [BITS_PER_LED-1:0] led_word_t;

  // Request codes
  typedef logic [2:0] req_t;
  localparam req_t REQ_WRITE = 3'd0;
  localparam req_t REQ_FILL  = 3'd1;
  localparam req_t REQ_CLEAR = 3'd2;
  localparam req_t REQ_SHOW  = 3'd3;
  localparam req_t REQ_TICK  = 3'd4;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CHAIN_LEN  = 3'd0;
  localparam cfg_idx_t CFG_ZERO_HIGH  = 3'd1;
  localparam cfg_idx_t CFG_ZERO_LOW   = 3'd2;
  localparam cfg_idx_t CFG_ONE_HIGH   = 3'd3;
  localparam cfg_idx_t CFG_ONE_LOW    = 3'd4;
  localparam cfg_idx_t CFG_LATCH      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_LATCH,
    ST_WALK,
    ST_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic write_px;
    logic walk_start;
    logic walk_clear;
    logic show_start;
    logic load_first;
    logic tick_bit;
    logic tick_latch;
    logic walk_step;
    logic emit;
    logic status;
    logic busy_res;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic idx_oob;
    logic show_done;
    logic latch_done;
    logic walk_done;
  } sts_t;

  function automatic led_word_t pack_colour(input logic [7:0] red,
                                            input logic [7:0] green,
                                            input logic [7:0] blue);
    led_word_t w;
    w = '0;
    w[BITS_PER_LED-1 -: 24] = {green, red, blue};
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ws2812_pixel_transmitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812_pixel_transmitter: single-wire LED chain driver
// Timing: the result word appears in the cycle after its request is taken;
//   a show start with LEDs first passes through a load state, busy high while
//   the first LED word is read out of the frame store RAM.
// Throughput: one request per cycle otherwise, so each tick advances the
//   line waveform by one step. Results cannot be stalled by the receiver.
// Reset: synchronous, sets config defaults, clears other regs, phase and
//   store valid bits; the store reads as all zero at once, no clearing pass.
// ----------------------------------------------------------------------------
module ws2812_pixel_transmitter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic [2:0]                      in_req_type,
  input  wire logic [7:0]                      in_pixel_index,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [wpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // result channel
  output      logic                            out_valid,
  output      logic                            out_line_level,
  output      logic                            out_busy_res,
  output      logic                            out_status
);
  import wpt_pkg::*;

  // The controller owns the phase (idle, bit, latch, walk, load) and decides
  // per request what the datapath does; the datapath owns every counter, the
  // frame store and the result word register.
  cmd_t cmd;
  sts_t sts;

  wpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Datapath prefetches the next LED word while the current one shifts out,
  // so an LED boundary leaves no gap in the bit stream.
  wpt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .pixel_index    (in_pixel_index),
    .red            (in_red),
    .green          (in_green),
    .blue           (in_blue),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

@@ rtl/wpt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wpt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/wpt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpt_ctrl: request sequencer of the pixel transmitter
// Decodes each request against the current phase and issues datapath commands.
// ----------------------------------------------------------------------------
module wpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [2:0]    req_type,
  input  wire wpt_pkg::sts_t sts,
  output      logic          busy,
  output      wpt_pkg::cmd_t cmd
);
  import wpt_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r == ST_LOAD);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    if (state_r == ST_LOAD) begin
      // first LED word is now out of the store
      cmd.load_first = 1'b1;
      cmd.emit       = 1'b1;
      state_nxt      = ST_BIT;
    end else if (accept) begin
      cmd.emit = 1'b1;
      if (req_type == REQ_TICK) begin
        unique case (state_r)
          ST_BIT: begin
            cmd.tick_bit = 1'b1;
            if (sts.show_done) state_nxt = ST_LATCH;
          end
          ST_LATCH: begin
            cmd.tick_latch = 1'b1;
            if (sts.latch_done) state_nxt = ST_IDLE;
          end
          ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done) state_nxt = ST_IDLE;
          end
          default: begin
          end
        endcase
      end else if (req_type > REQ_TICK || state_r != ST_IDLE) begin
        cmd.status = 1'b1;
      end else begin
        unique case (req_type)
          REQ_WRITE: begin
            if (sts.idx_oob) begin
              cmd.status = 1'b1;
            end else begin
              cmd.write_px = 1'b1;
            end
          end
          REQ_FILL, REQ_CLEAR: begin
            cmd.walk_start = 1'b1;
            cmd.walk_clear = (req_type == REQ_CLEAR);
            if (!sts.count_zero) state_nxt = ST_WALK;
          end
          REQ_SHOW: begin
            cmd.show_start = 1'b1;
            if (sts.count_zero) begin
              state_nxt = ST_LATCH;
            end else begin
              // hold the result until the first word is loaded
              cmd.emit  = 1'b0;
              state_nxt = ST_LOAD;
            end
          end
          default: begin
            cmd.status = 1'b1;
          end
        endcase
      end
    end
    cmd.busy_res = (state_nxt != ST_IDLE);
  end

endmodule
`default_nettype wire

@@ rtl/wpt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wpt_datapath: frame store, bit timing and result registers
// Holds the configuration, the frame store with its valid bits, the LED
// shift word with bit and tick counters, and the registered result word.
// ----------------------------------------------------------------------------
module wpt_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire wpt_pkg::cmd_t                    cmd,
  input  wire logic [7:0]                       pixel_index,
  input  wire logic [7:0]                       red,
  input  wire logic [7:0]                       green,
  input  wire logic [7:0]                       blue,
  input  wire logic                             cfg_we,
  input  wire logic [wpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wpt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output      wpt_pkg::sts_t                    sts,
  output      logic                             out_valid,
  output      logic                             out_line_level,
  output      logic                             out_busy_res,
  output      logic                             out_status
);
  import wpt_pkg::*;

  // configuration
  logic [COUNT_W-1:0] chain_len_r;
  logic [TIME_W-1:0]  zero_high_r;
  logic [TIME_W-1:0]  zero_low_r;
  logic [TIME_W-1:0]  one_high_r;
  logic [TIME_W-1:0]  one_low_r;
  logic [TICK_W-1:0]  latch_ticks_r;

  // transmit state
  logic [COUNT_W-1:0]  led_pointer_r,  led_pointer_nxt;
  logic [BITPOS_W-1:0] bit_position_r, bit_position_nxt;
  led_word_t           shift_word_r,   shift_word_nxt;
  logic [TICK_W-1:0]   phase_ticks_r,  phase_ticks_nxt;
  led_word_t           fill_colour_r,  fill_colour_nxt;

  logic [MAX_LEDS-1:0] valid_r;
  logic                rd_valid_r;

  logic out_valid_r, out_level_r, out_busy_r, out_status_r;

  // store ports
  logic                 ram_we;
  logic [LED_IDX_W-1:0] ram_waddr;
  led_word_t            ram_wdata;
  logic                 ram_re;
  logic [LED_IDX_W-1:0] ram_raddr;
  led_word_t            ram_rdata;
  led_word_t            rd_word;

  // derived values
  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] ptr_inc;
  logic [COUNT_W-1:0] ptr_inc2;
  logic               cur_bit;
  logic [TIME_W-1:0]  hi_ticks;
  logic [TIME_W-1:0]  lo_ticks;
  logic [TIME_W:0]    bit_ticks;
  logic [TICK_W-1:0]  pt_inc;
  logic               bit_end;
  logic               led_end;
  logic               level;

  wpt_ram #(
    .WIDTH (BITS_PER_LED),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  assign rd_word = rd_valid_r ? ram_rdata : '0;

  assign count_eff = (chain_len_r > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS) : chain_len_r;
  assign ptr_inc   = led_pointer_r + COUNT_W'(1);
  assign ptr_inc2  = ptr_inc + COUNT_W'(1);
  assign cur_bit   = shift_word_r[BITS_PER_LED-1];
  assign hi_ticks  = cur_bit ? one_high_r : zero_high_r;
  assign lo_ticks  = cur_bit ? one_low_r  : zero_low_r;
  assign bit_ticks = {1'b0, hi_ticks} + {1'b0, lo_ticks};
  assign pt_inc    = phase_ticks_r + TICK_W'(1);
  assign bit_end   = (pt_inc >= TICK_W'(bit_ticks));
  assign led_end   = (ptr_inc >= count_eff);
  assign level     = (phase_ticks_r < TICK_W'(hi_ticks));

  assign sts.count_zero = (count_eff == '0);
  assign sts.idx_oob    = ({1'b0, pixel_index} >= count_eff);
  assign sts.show_done  = bit_end && (bit_position_r == '0) && led_end;
  assign sts.latch_done = (pt_inc >= latch_ticks_r);
  assign sts.walk_done  = led_end;

  always_comb begin
    led_pointer_nxt  = led_pointer_r;
    bit_position_nxt = bit_position_r;
    shift_word_nxt   = shift_word_r;
    phase_ticks_nxt  = phase_ticks_r;
    fill_colour_nxt  = fill_colour_r;
    ram_we    = 1'b0;
    ram_waddr = pixel_index[LED_IDX_W-1:0];
    ram_wdata = pack_colour(red, green, blue);
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (cmd.write_px) begin
      ram_we = 1'b1;
    end

    if (cmd.walk_start) begin
      fill_colour_nxt = cmd.walk_clear ? '0 : pack_colour(red, green, blue);
      led_pointer_nxt = '0;
    end

    if (cmd.walk_step) begin
      if (led_pointer_r < count_eff) begin
        ram_we    = 1'b1;
        ram_waddr = led_pointer_r[LED_IDX_W-1:0];
        ram_wdata = fill_colour_r;
      end
      led_pointer_nxt = ptr_inc;
    end

    if (cmd.show_start) begin
      // fetch LED zero now, it is loaded in the next cycle
      led_pointer_nxt = '0;
      phase_ticks_nxt = '0;
      ram_re          = 1'b1;
      ram_raddr       = '0;
    end

    if (cmd.load_first) begin
      shift_word_nxt   = rd_word;
      bit_position_nxt = BITPOS_W'(BITS_PER_LED - 1);
      phase_ticks_nxt  = '0;
      // prefetch the following LED
      ram_re           = 1'b1;
      ram_raddr        = ptr_inc[LED_IDX_W-1:0];
    end

    if (cmd.tick_bit) begin
      phase_ticks_nxt = pt_inc;
      if (bit_end) begin
        phase_ticks_nxt = '0;
        if (bit_position_r == '0) begin
          led_pointer_nxt = ptr_inc;
          if (!led_end) begin
            shift_word_nxt   = rd_word;
            bit_position_nxt = BITPOS_W'(BITS_PER_LED - 1);
            ram_re           = 1'b1;
            ram_raddr        = ptr_inc2[LED_IDX_W-1:0];
          end
        end else begin
          bit_position_nxt = bit_position_r - BITPOS_W'(1);
          shift_word_nxt   = {shift_word_r[BITS_PER_LED-2:0], 1'b0};
        end
      end
    end

    if (cmd.tick_latch) begin
      phase_ticks_nxt = sts.latch_done ? '0 : pt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r    <= COUNT_W'(256);
      zero_high_r    <= TIME_W'(18);
      zero_low_r     <= TIME_W'(40);
      one_high_r     <= TIME_W'(35);
      one_low_r      <= TIME_W'(30);
      latch_ticks_r  <= TICK_W'(3000);
      led_pointer_r  <= '0;
      bit_position_r <= '0;
      shift_word_r   <= '0;
      phase_ticks_r  <= '0;
      fill_colour_r  <= '0;
      valid_r        <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      out_level_r    <= 1'b0;
      out_busy_r     <= 1'b0;
      out_status_r   <= 1'b0;
    end else begin
      led_pointer_r  <= led_pointer_nxt;
      bit_position_r <= bit_position_nxt;
      shift_word_r   <= shift_word_nxt;
      phase_ticks_r  <= phase_ticks_nxt;
      fill_colour_r  <= fill_colour_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_r <= valid_r[ram_raddr];
      end
      out_valid_r  <= cmd.emit;
      out_level_r  <= cmd.tick_bit && level;
      out_busy_r   <= cmd.busy_res;
      out_status_r <= cmd.status;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHAIN_LEN: chain_len_r   <= cfg_wdata[COUNT_W-1:0];
          CFG_ZERO_HIGH: zero_high_r   <= cfg_wdata[TIME_W-1:0];
          CFG_ZERO_LOW:  zero_low_r    <= cfg_wdata[TIME_W-1:0];
          CFG_ONE_HIGH:  one_high_r    <= cfg_wdata[TIME_W-1:0];
          CFG_ONE_LOW:   one_low_r     <= cfg_wdata[TIME_W-1:0];
          CFG_LATCH:     latch_ticks_r <= cfg_wdata[TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_level_r;
  assign out_busy_res   = out_busy_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire
